### rtl/indexed_list_with_insert_erase_unit_assert.svh
// Assertion macros shared by the list unit. Each one expects clk and rst_n
// to be visible at the point of use.
`ifndef INDEXED_LIST_WITH_INSERT_ERASE_UNIT_ASSERT_SVH
`define INDEXED_LIST_WITH_INSERT_ERASE_UNIT_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define ILIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// When pre holds at one edge, post must hold at the next edge.
`define ILIE_ASSERT_NEXT(lbl, pre, post, msg) \
  `ILIE_ASSERT(lbl, (pre) |=> (post), msg)

`endif

### rtl/ilie_pkg.sv
package ilie_pkg;

  localparam int WORD_W = 32;
  localparam int CMD_W = 3;
  localparam int POS_W = 7;
  localparam int CNT_W = 7;
  localparam int STAT_W = 2;

  // Wide enough for any index or count up to the largest supported capacity.
  localparam int IDX_W = 11;
  localparam int MAX_CAPACITY = 1024;
  localparam int DEF_CAPACITY = 64;

  // Taps OR-ed together in the first, registered level of a gather tree.
  localparam int GATHER_GROUP = 8;

  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd5;
  localparam logic [CMD_W-1:0] CMD_FILL = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
    logic [CNT_W-1:0]         fill_count;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] read_value;
    logic [CNT_W-1:0]         count;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
  } out_item_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic              en;
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  pos;
    logic [IDX_W-1:0]  count;
    logic [IDX_W-1:0]  fcnt;
    logic [WORD_W-1:0] value;
  } cell_ctl_t;

  // Indexes whose cells put their word on the gather trees.
  typedef struct packed {
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] bk_idx;
  } cell_sel_t;

endpackage

### rtl/ilie_cell.sv
module ilie_cell #(
  parameter int IDX = 0
) (
  input  logic                           clk,
  input  ilie_pkg::cell_ctl_t            ctl,
  input  ilie_pkg::cell_sel_t            sel,
  input  logic [ilie_pkg::WORD_W-1:0]    left_data,
  input  logic [ilie_pkg::WORD_W-1:0]    right_data,
  output logic [ilie_pkg::WORD_W-1:0]    data_r,
  output logic [ilie_pkg::WORD_W-1:0]    rd_tap,
  output logic [ilie_pkg::WORD_W-1:0]    bk_tap
);

  localparam logic [ilie_pkg::IDX_W-1:0] MY_IDX = ilie_pkg::IDX_W'(IDX);

  logic [ilie_pkg::WORD_W-1:0] data_nxt;

  // Each cell decides from the broadcast command whether it keeps its word,
  // loads the new value, or takes the word of a neighbor.
  always_comb begin
    data_nxt = data_r;
    if (ctl.en) begin
      case (ctl.cmd)
        ilie_pkg::CMD_PUSH: begin
          if (MY_IDX == ctl.count) data_nxt = ctl.value;
        end
        ilie_pkg::CMD_INSERT: begin
          if (MY_IDX == ctl.pos) begin
            data_nxt = ctl.value;
          end else if (MY_IDX > ctl.pos && MY_IDX <= ctl.count) begin
            data_nxt = left_data;
          end
        end
        ilie_pkg::CMD_ERASE: begin
          if (MY_IDX >= ctl.pos && MY_IDX < ctl.count) data_nxt = right_data;
        end
        ilie_pkg::CMD_WRITE: begin
          if (MY_IDX == ctl.pos) data_nxt = ctl.value;
        end
        ilie_pkg::CMD_FILL: begin
          if (MY_IDX < ctl.fcnt) data_nxt = ctl.value;
        end
        default: data_nxt = data_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign rd_tap = (MY_IDX == sel.rd_idx) ? data_r : '0;
  assign bk_tap = (MY_IDX == sel.bk_idx) ? data_r : '0;

endmodule

### rtl/ilie_gather.sv
module ilie_gather #(
  parameter int N = ilie_pkg::DEF_CAPACITY
) (
  input  logic                                 clk,
  input  logic [N-1:0][ilie_pkg::WORD_W-1:0]   taps,
  output logic [ilie_pkg::WORD_W-1:0]          result
);

  localparam int GROUP = ilie_pkg::GATHER_GROUP;
  localparam int NG = (N + GROUP - 1) / GROUP;

  logic [NG-1:0][ilie_pkg::WORD_W-1:0] grp_r;
  logic [NG-1:0][ilie_pkg::WORD_W-1:0] grp_nxt;

  // At most one tap is nonzero, so OR-ing the taps selects it.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < N) grp_nxt[g] = grp_nxt[g] | taps[g * GROUP + k];
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  always_comb begin
    result = '0;
    for (int g = 0; g < NG; g++) begin
      result = result | grp_r[g];
    end
  end

endmodule

### rtl/indexed_list_with_insert_erase_unit.sv
// Bounded ordered list of signed 32-bit words, driven one command per beat.
// The input channel (in_valid, in_stall, in_data) carries one command beat:
// push, pop, insert, erase, read, write or fill. The result channel
// (out_valid, out_stall, out_data) returns exactly one beat per command with
// the status, the read word, the live count and the front and back words.
// Every entry lives in its own cell of a chain; insert and erase move all
// affected words to their neighbors in the same clock, so the list itself
// is updated at the edge that accepts the command.
// The read and back words are then collected from the chain through a
// two-level OR tree, one registered level: the select indexes, the first
// tree level and the result beat are registered in that order. The unit
// holds one command at a time and takes the next one in the cycle in which
// the result is taken. When the receiver stalls, the result beat is held
// unchanged and in_stall stays high until it is taken.
// Reset empties the list (count zero) and clears all handshake state; the
// stored words are not cleared, since only live entries are ever read.
`include "indexed_list_with_insert_erase_unit_assert.svh"

module indexed_list_with_insert_erase_unit #(
  parameter int CAPACITY = ilie_pkg::DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ilie_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ilie_pkg::out_item_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [ilie_pkg::IDX_W-1:0] CAP_X = ilie_pkg::IDX_W'(CAPACITY);

  // Live count and the handshake pipeline.
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          s1_v_r;
  logic          s2_v_r;
  logic          out_valid_r;
  logic          accept;

  // Command bookkeeping carried alongside the gather pipeline.
  logic [ilie_pkg::STAT_W-1:0] s1_status_r;
  logic [ilie_pkg::STAT_W-1:0] s2_status_r;
  logic                        s1_is_read_r;
  logic                        s2_is_read_r;
  logic [CW-1:0]               s1_count_r;
  logic [CW-1:0]               s2_count_r;
  ilie_pkg::cell_sel_t         s1_sel_r;
  ilie_pkg::out_item_t         out_data_r;

  logic [ilie_pkg::STAT_W-1:0] status_c;
  logic [ilie_pkg::IDX_W-1:0]  pos_x;
  logic [ilie_pkg::IDX_W-1:0]  count_x;
  logic [ilie_pkg::IDX_W-1:0]  fcnt_x;
  logic [ilie_pkg::IDX_W-1:0]  new_count_x;
  ilie_pkg::cell_ctl_t         ctl;
  ilie_pkg::out_item_t         result_c;

  logic [CAPACITY-1:0][ilie_pkg::WORD_W-1:0] cell_data;
  logic [CAPACITY-1:0][ilie_pkg::WORD_W-1:0] rd_taps;
  logic [CAPACITY-1:0][ilie_pkg::WORD_W-1:0] bk_taps;
  logic [ilie_pkg::WORD_W-1:0]               rd_word;
  logic [ilie_pkg::WORD_W-1:0]               bk_word;

  // A new command may enter only when nothing is in flight, or when the
  // result beat of the previous command leaves at this edge.
  assign in_stall = s1_v_r | s2_v_r | (out_valid_r & out_stall);
  assign accept = in_valid & ~in_stall;

  assign pos_x = ilie_pkg::IDX_W'(in_data.position);
  assign count_x = ilie_pkg::IDX_W'(count_r);
  assign fcnt_x = ilie_pkg::IDX_W'(in_data.fill_count);

  // Status check; a failed command leaves the list untouched.
  always_comb begin
    status_c = ilie_pkg::ST_OK;
    new_count_x = count_x;
    case (in_data.cmd)
      ilie_pkg::CMD_PUSH: begin
        if (count_x >= CAP_X) status_c = ilie_pkg::ST_FULL;
        else new_count_x = count_x + 1'b1;
      end
      ilie_pkg::CMD_POP: begin
        if (count_x == '0) status_c = ilie_pkg::ST_EMPTY;
        else new_count_x = count_x - 1'b1;
      end
      ilie_pkg::CMD_INSERT: begin
        // Position is checked before fullness.
        if (pos_x > count_x) status_c = ilie_pkg::ST_RANGE;
        else if (count_x >= CAP_X) status_c = ilie_pkg::ST_FULL;
        else new_count_x = count_x + 1'b1;
      end
      ilie_pkg::CMD_ERASE: begin
        if (pos_x >= count_x) status_c = ilie_pkg::ST_RANGE;
        else new_count_x = count_x - 1'b1;
      end
      ilie_pkg::CMD_READ, ilie_pkg::CMD_WRITE: begin
        if (pos_x >= count_x) status_c = ilie_pkg::ST_RANGE;
      end
      ilie_pkg::CMD_FILL: begin
        if (fcnt_x > CAP_X) status_c = ilie_pkg::ST_FULL;
        else new_count_x = fcnt_x;
      end
      default: status_c = ilie_pkg::ST_RANGE;
    endcase
  end

  assign count_nxt = CW'(new_count_x);

  always_comb begin
    ctl.en = accept && (status_c == ilie_pkg::ST_OK);
    ctl.cmd = in_data.cmd;
    ctl.pos = pos_x;
    ctl.count = count_x;
    ctl.fcnt = fcnt_x;
    ctl.value = in_data.value;
  end

  // The chain of cells: cell i sees the words of cells i-1 and i+1. The end
  // cells see their own word where no neighbor exists.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ilie_pkg::WORD_W-1:0] left_w;
    logic [ilie_pkg::WORD_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = cell_data[i];
    end else begin : g_left
      assign left_w = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_right
      assign right_w = cell_data[i+1];
    end

    ilie_cell #(
      .IDX(i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .sel        (s1_sel_r),
      .left_data  (left_w),
      .right_data (right_w),
      .data_r     (cell_data[i]),
      .rd_tap     (rd_taps[i]),
      .bk_tap     (bk_taps[i])
    );
  end

  ilie_gather #(
    .N(CAPACITY)
  ) u_gather_rd (
    .clk    (clk),
    .taps   (rd_taps),
    .result (rd_word)
  );

  ilie_gather #(
    .N(CAPACITY)
  ) u_gather_bk (
    .clk    (clk),
    .taps   (bk_taps),
    .result (bk_word)
  );

  // Result beat, assembled while the second gather level settles. The front
  // word is cell zero, which cannot change while a command is in flight.
  always_comb begin
    result_c.status = s2_status_r;
    if (s2_status_r != ilie_pkg::ST_OK) begin
      result_c.read_value = '1;
    end else if (s2_is_read_r) begin
      result_c.read_value = rd_word;
    end else begin
      result_c.read_value = '0;
    end
    result_c.count = ilie_pkg::CNT_W'(s2_count_r);
    if (s2_count_r == '0) begin
      result_c.front_value = '1;
      result_c.back_value = '1;
    end else begin
      result_c.front_value = cell_data[0];
      result_c.back_value = bk_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) count_r <= count_nxt;
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      if (s2_v_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= status_c;
      s1_is_read_r <= (in_data.cmd == ilie_pkg::CMD_READ);
      s1_count_r <= count_nxt;
      s1_sel_r.rd_idx <= pos_x;
      s1_sel_r.bk_idx <= ilie_pkg::IDX_W'(count_nxt - 1'b1);
    end
    if (s1_v_r) begin
      s2_status_r <= s1_status_r;
      s2_is_read_r <= s1_is_read_r;
      s2_count_r <= s1_count_r;
    end
    if (s2_v_r) out_data_r <= result_c;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  `ILIE_ASSERT(a_count_bound, count_r <= CW'(CAPACITY), "live count above capacity")
  `ILIE_ASSERT(a_one_in_flight, $onehot0({s1_v_r, s2_v_r, out_valid_r}), "two commands in flight")
  `ILIE_ASSERT_NEXT(a_accept_enters, accept, s1_v_r, "accepted command lost")
  `ILIE_ASSERT_NEXT(a_result_follows, s2_v_r, out_valid_r, "gather stage did not reach output")

endmodule

### sim/tb_indexed_list_with_insert_erase_unit.sv
`timescale 1ns / 1ps

module tb_indexed_list_with_insert_erase_unit;

  // The unit is built with its default capacity, so the shadow list matches it.
  localparam int LIST_DEPTH = ilie_pkg::DEF_CAPACITY;
  // Command code 7 is not defined by the unit and must be rejected as out of range.
  localparam logic [ilie_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;
  // All ones is the word that the unit reports for a missing entry or an error.
  localparam logic [ilie_pkg::WORD_W-1:0] NO_WORD = '1;
  localparam logic [ilie_pkg::WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [ilie_pkg::WORD_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [ilie_pkg::WORD_W-1:0] FILL_WORD = 32'hA5A5_A5A5;
  localparam int RANDOM_BEATS = 1400;
  localparam int MAX_REPORTS = 100;

  // One row of the directed table. When typed is set, the result is written out
  // by hand. Otherwise the shadow list works out the expected result.
  typedef struct packed {
    ilie_pkg::in_item_t  beat;
    logic                typed;
    ilie_pkg::out_item_t result;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ilie_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ilie_pkg::out_item_t out_data;

  // The shadow copy of the list, kept in step with every accepted command beat.
  logic [ilie_pkg::WORD_W-1:0] shadow_words [LIST_DEPTH];
  int                          shadow_len = 0;
  // Expected result beats, oldest first.
  ilie_pkg::out_item_t         list_results_due[$];
  ilie_pkg::out_item_t         due;
  dir_row_t                    directed_rows[$];
  int                          send_gap_pct = 0;
  int                          recv_stall_pct = 0;
  int                          err_count = 0;
  int                          result_seq = 0;
  // The random commands lean toward growing the list until it is full, and then
  // toward shrinking it until it is empty. Both the full and the empty edge are
  // therefore reached again and again.
  bit                          growing = 1'b1;

  indexed_list_with_insert_erase_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // The receiver stalls at random, one decision per clock.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("ERROR at %0t ns: %s", $time, what);
    end
  endtask

  // Applies one command to the shadow list and returns the result beat that the
  // unit must produce for it. A rejected command leaves the list untouched.
  function automatic ilie_pkg::out_item_t list_apply(input ilie_pkg::in_item_t c);
    ilie_pkg::out_item_t r;
    int                  p;
    int                  n;
    r = '0;
    r.status = ilie_pkg::ST_OK;
    p = int'(c.position);
    n = int'(c.fill_count);
    case (c.cmd)
      ilie_pkg::CMD_PUSH: begin
        if (shadow_len >= LIST_DEPTH) begin
          r.status = ilie_pkg::ST_FULL;
        end else begin
          shadow_words[shadow_len] = c.value;
          shadow_len++;
        end
      end
      ilie_pkg::CMD_POP: begin
        if (shadow_len == 0) begin
          r.status = ilie_pkg::ST_EMPTY;
        end else begin
          shadow_len--;
        end
      end
      ilie_pkg::CMD_INSERT: begin
        // The position is checked before the free room.
        if (p > shadow_len) begin
          r.status = ilie_pkg::ST_RANGE;
        end else if (shadow_len >= LIST_DEPTH) begin
          r.status = ilie_pkg::ST_FULL;
        end else begin
          for (int i = shadow_len; i > p; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[p] = c.value;
          shadow_len++;
        end
      end
      ilie_pkg::CMD_ERASE: begin
        if (p >= shadow_len) begin
          r.status = ilie_pkg::ST_RANGE;
        end else begin
          for (int i = p; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
        end
      end
      ilie_pkg::CMD_READ: begin
        if (p >= shadow_len) begin
          r.status = ilie_pkg::ST_RANGE;
        end else begin
          r.read_value = shadow_words[p];
        end
      end
      ilie_pkg::CMD_WRITE: begin
        if (p >= shadow_len) begin
          r.status = ilie_pkg::ST_RANGE;
        end else begin
          shadow_words[p] = c.value;
        end
      end
      ilie_pkg::CMD_FILL: begin
        // A fill of zero entries is legal and leaves the list empty.
        if (n > LIST_DEPTH) begin
          r.status = ilie_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < n; i++) shadow_words[i] = c.value;
          shadow_len = n;
        end
      end
      default: begin
        r.status = ilie_pkg::ST_RANGE;
      end
    endcase
    if (r.status != ilie_pkg::ST_OK) r.read_value = NO_WORD;
    r.count = ilie_pkg::CNT_W'(shadow_len);
    if (shadow_len == 0) begin
      r.front_value = NO_WORD;
      r.back_value = NO_WORD;
    end else begin
      r.front_value = shadow_words[0];
      r.back_value = shadow_words[shadow_len-1];
    end
    return r;
  endfunction

  // Builds one random command beat from the current state of the shadow list.
  // Most beats are legal commands at live positions. A few carry positions or
  // fill counts out of range, and a few are raw noise that includes the
  // unused command code.
  function automatic ilie_pkg::in_item_t next_list_cmd();
    ilie_pkg::in_item_t c;
    int                 roll;
    int                 last;
    c.cmd = ilie_pkg::CMD_READ;
    c.value = $urandom;
    c.fill_count = ilie_pkg::CNT_W'($urandom_range(0, LIST_DEPTH));
    last = (shadow_len > 0) ? shadow_len - 1 : 0;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      c.cmd = ilie_pkg::CMD_W'($urandom_range(0, 7));
    end else if (roll < 5) begin
      c.cmd = ilie_pkg::CMD_FILL;
    end else if (roll < 40) begin
      if (growing) begin
        c.cmd = ($urandom_range(0, 1) != 0) ? ilie_pkg::CMD_PUSH : ilie_pkg::CMD_INSERT;
      end else begin
        c.cmd = ($urandom_range(0, 1) != 0) ? ilie_pkg::CMD_POP : ilie_pkg::CMD_ERASE;
      end
    end else if (roll < 55) begin
      if (growing) begin
        c.cmd = ($urandom_range(0, 1) != 0) ? ilie_pkg::CMD_POP : ilie_pkg::CMD_ERASE;
      end else begin
        c.cmd = ($urandom_range(0, 1) != 0) ? ilie_pkg::CMD_PUSH : ilie_pkg::CMD_INSERT;
      end
    end else if (roll < 78) begin
      c.cmd = ilie_pkg::CMD_READ;
    end else begin
      c.cmd = ilie_pkg::CMD_WRITE;
    end

    // An insert may also land one past the last entry, which is an append.
    if (c.cmd == ilie_pkg::CMD_INSERT) begin
      c.position = ilie_pkg::POS_W'($urandom_range(0, shadow_len));
    end else begin
      c.position = ilie_pkg::POS_W'($urandom_range(0, last));
    end
    roll = $urandom_range(0, 99);
    if (roll < 7 || c.cmd == CMD_UNUSED) begin
      c.position = ilie_pkg::POS_W'($urandom_range(0, 127));
    end else if (roll < 11) begin
      c.position = '0;
    end else if (roll < 15) begin
      c.position = ilie_pkg::POS_W'((c.cmd == ilie_pkg::CMD_INSERT) ? shadow_len : last);
    end

    if ($urandom_range(0, 99) < 10) begin
      c.fill_count = ilie_pkg::CNT_W'($urandom_range(LIST_DEPTH + 1, 127));
    end
    if ($urandom_range(0, 99) < 10) begin
      case ($urandom_range(0, 3))
        0: c.value = '0;
        1: c.value = NO_WORD;
        2: c.value = WORD_MAX;
        default: c.value = WORD_MIN;
      endcase
    end
    return c;
  endfunction

  task automatic add_row(input logic [ilie_pkg::CMD_W-1:0] cmd, input int pos,
                         input logic [ilie_pkg::WORD_W-1:0] val, input int fcnt);
    dir_row_t row;
    row = '0;
    row.beat.cmd = cmd;
    row.beat.position = ilie_pkg::POS_W'(pos);
    row.beat.value = val;
    row.beat.fill_count = ilie_pkg::CNT_W'(fcnt);
    directed_rows = {directed_rows, row};
  endtask

  task automatic add_checked_row(input logic [ilie_pkg::CMD_W-1:0] cmd, input int pos,
                                 input logic [ilie_pkg::WORD_W-1:0] val, input int fcnt,
                                 input logic [ilie_pkg::STAT_W-1:0] st,
                                 input logic [ilie_pkg::WORD_W-1:0] rd,
                                 input int cnt, input logic [ilie_pkg::WORD_W-1:0] fr,
                                 input logic [ilie_pkg::WORD_W-1:0] bk);
    dir_row_t row;
    row.beat.cmd = cmd;
    row.beat.position = ilie_pkg::POS_W'(pos);
    row.beat.value = val;
    row.beat.fill_count = ilie_pkg::CNT_W'(fcnt);
    row.typed = 1'b1;
    row.result.status = st;
    row.result.read_value = rd;
    row.result.count = ilie_pkg::CNT_W'(cnt);
    row.result.front_value = fr;
    row.result.back_value = bk;
    directed_rows = {directed_rows, row};
  endtask

  // Offers one command beat and holds it unchanged until the unit takes it. The
  // sender may idle first. Valid is lowered only when a gap really follows, so a
  // back-to-back beat never sees valid dropped and raised in one time step.
  task automatic send_beat(input ilie_pkg::in_item_t b, input logic typed,
                           input ilie_pkg::out_item_t typed_result);
    ilie_pkg::out_item_t predicted;
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    // The beat was accepted at this edge. The shadow list moves with it.
    predicted = list_apply(b);
    if (typed) predicted = typed_result;
    list_results_due = {list_results_due, predicted};
  endtask

  // Stops offering beats until every expected result beat has come back. This
  // always advances at least one clock, so valid changes only once per step.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (list_results_due.size() != 0);
  endtask

  // Checks each result beat that the receiver takes against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      result_seq++;
      if (list_results_due.size() == 0) begin
        report_mismatch($sformatf("result beat %0d arrived with nothing expected", result_seq));
      end else begin
        due = list_results_due.pop_front();
        if (out_data.status !== due.status)
          report_mismatch($sformatf("beat %0d status got %0d want %0d",
                                    result_seq, out_data.status, due.status));
        if (out_data.read_value !== due.read_value)
          report_mismatch($sformatf("beat %0d read_value got %0d want %0d",
                                    result_seq, out_data.read_value, due.read_value));
        if (out_data.count !== due.count)
          report_mismatch($sformatf("beat %0d count got %0d want %0d",
                                    result_seq, out_data.count, due.count));
        if (out_data.front_value !== due.front_value)
          report_mismatch($sformatf("beat %0d front_value got %0d want %0d",
                                    result_seq, out_data.front_value, due.front_value));
        if (out_data.back_value !== due.back_value)
          report_mismatch($sformatf("beat %0d back_value got %0d want %0d",
                                    result_seq, out_data.back_value, due.back_value));
      end
    end
  end

  // The run stops here if the unit hangs. This bound is far above the slowest
  // legal run.
  initial begin
    #2_000_000;
    $display("FAIL indexed_list_with_insert_erase_unit");
    $finish;
  end

  initial begin
    // The rows below start on an empty list and cover its rejected cases first.
    // Then come the word extremes, inserts at the front and the back, erases at
    // both ends, and the full list.
    add_checked_row(ilie_pkg::CMD_POP, 0, '0, 0, ilie_pkg::ST_EMPTY, NO_WORD, 0,
                    NO_WORD, NO_WORD);
    add_checked_row(ilie_pkg::CMD_READ, 0, '0, 0, ilie_pkg::ST_RANGE, NO_WORD, 0,
                    NO_WORD, NO_WORD);
    add_checked_row(ilie_pkg::CMD_ERASE, 0, '0, 0, ilie_pkg::ST_RANGE, NO_WORD, 0,
                    NO_WORD, NO_WORD);
    add_checked_row(ilie_pkg::CMD_WRITE, 0, 32'd1, 0, ilie_pkg::ST_RANGE, NO_WORD, 0,
                    NO_WORD, NO_WORD);
    add_checked_row(CMD_UNUSED, 0, '0, 0, ilie_pkg::ST_RANGE, NO_WORD, 0,
                    NO_WORD, NO_WORD);
    add_checked_row(ilie_pkg::CMD_INSERT, 1, 32'd3, 0, ilie_pkg::ST_RANGE, NO_WORD, 0,
                    NO_WORD, NO_WORD);
    add_checked_row(ilie_pkg::CMD_FILL, 0, 32'd5, 0, ilie_pkg::ST_OK, '0, 0,
                    NO_WORD, NO_WORD);
    add_checked_row(ilie_pkg::CMD_FILL, 0, 32'd5, 127, ilie_pkg::ST_FULL, NO_WORD, 0,
                    NO_WORD, NO_WORD);
    add_checked_row(ilie_pkg::CMD_PUSH, 0, WORD_MAX, 0, ilie_pkg::ST_OK, '0, 1,
                    WORD_MAX, WORD_MAX);
    add_checked_row(ilie_pkg::CMD_PUSH, 127, WORD_MIN, 127, ilie_pkg::ST_OK, '0, 2,
                    WORD_MAX, WORD_MIN);
    add_row(ilie_pkg::CMD_INSERT, 0, NO_WORD, 0);
    add_row(ilie_pkg::CMD_INSERT, 3, '0, 0);
    add_row(ilie_pkg::CMD_READ, 3, '0, 0);
    add_row(ilie_pkg::CMD_READ, 127, NO_WORD, 0);
    add_row(ilie_pkg::CMD_WRITE, 1, 32'h5A5A_5A5A, 0);
    add_row(ilie_pkg::CMD_ERASE, 0, '0, 0);
    add_row(ilie_pkg::CMD_ERASE, 2, '0, 0);
    add_row(ilie_pkg::CMD_INSERT, 1, 32'h0000_1234, 0);
    add_checked_row(ilie_pkg::CMD_FILL, 0, FILL_WORD, LIST_DEPTH, ilie_pkg::ST_OK, '0,
                    LIST_DEPTH, FILL_WORD, FILL_WORD);
    add_checked_row(ilie_pkg::CMD_PUSH, 0, '0, 0, ilie_pkg::ST_FULL, NO_WORD, LIST_DEPTH,
                    FILL_WORD, FILL_WORD);
    add_checked_row(ilie_pkg::CMD_INSERT, 0, '0, 0, ilie_pkg::ST_FULL, NO_WORD, LIST_DEPTH,
                    FILL_WORD, FILL_WORD);
    add_checked_row(ilie_pkg::CMD_INSERT, LIST_DEPTH + 1, '0, 0, ilie_pkg::ST_RANGE,
                    NO_WORD, LIST_DEPTH, FILL_WORD, FILL_WORD);
    add_row(ilie_pkg::CMD_WRITE, LIST_DEPTH - 1, '0, 0);
    add_row(ilie_pkg::CMD_ERASE, 0, '0, 0);
    add_row(ilie_pkg::CMD_POP, 0, '0, 0);
    add_checked_row(ilie_pkg::CMD_FILL, 0, '0, 1, ilie_pkg::ST_OK, '0, 1, '0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // The directed beats run with a slow receiver, as in the first random phase.
    send_gap_pct = 23;
    recv_stall_pct = 70;
    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].result);
    end
    // The sender holds off here until the unit has nothing left in flight.
    drain_results();

    // Three random phases. The first has a busy receiver, the second a lazy
    // sender, and the third runs at full rate with no gaps on either side.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 23;
          recv_stall_pct = 70;
        end
        1: begin
          send_gap_pct = 70;
          recv_stall_pct = 23;
        end
        default: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      repeat (RANDOM_BEATS / 3) begin
        send_beat(next_list_cmd(), 1'b0, '0);
        if (shadow_len >= LIST_DEPTH) growing = 1'b0;
        else if (shadow_len == 0) growing = 1'b1;
      end
      drain_results();
    end

    // Keep the clock running so that any stray result beat can still show up.
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS indexed_list_with_insert_erase_unit");
    end else begin
      $display("FAIL indexed_list_with_insert_erase_unit");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/ilie_pkg.sv
rtl/ilie_cell.sv
rtl/ilie_gather.sv
rtl/indexed_list_with_insert_erase_unit.sv
sim/tb_indexed_list_with_insert_erase_unit.sv
